FILE: hdl/aabbt_pkg.sv
// ----------------------------------------------------------------------------
// aabbt_pkg
// Shared widths, register indexes, reset values and stage control type for
// the affine box transform.
// ----------------------------------------------------------------------------
`default_nettype none

package aabbt_pkg;

   localparam int COORD_W   = 32;
   localparam int ELEM_W    = 16;
   localparam int COLUMN_W  = 3 * ELEM_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = COLUMN_W;
   localparam int AXES      = 3;
   localparam int FRAC_DROP = 13;

   localparam int SUM_W    = COORD_W + 1;          // lo + hi
   localparam int PROD_A_W = SUM_W + ELEM_W;       // m * s
   localparam int PROD_B_W = COORD_W + ELEM_W;     // |m| * d
   localparam int ACC_A_W  = PROD_A_W + 2;
   localparam int ACC_B_W  = PROD_B_W + 2;
   localparam int EDGE_W   = ACC_A_W + 1;          // A +/- B
   localparam int SHIFT_W  = EDGE_W - FRAC_DROP;
   localparam int OUT_W    = SHIFT_W + 1;          // with translation

   localparam int REQ_DATA_W = 2 * AXES * COORD_W;
   localparam int RSP_DATA_W = 2 * AXES * COORD_W;

   localparam logic [CSR_IDX_W-1:0] REG_COLUMN0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

   localparam logic [COLUMN_W-1:0] COLUMN0_RESET = 48'h0000_0000_1000;
   localparam logic [COLUMN_W-1:0] COLUMN1_RESET = 48'h0000_1000_0000;
   localparam logic [COLUMN_W-1:0] COLUMN2_RESET = 48'h1000_0000_0000;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

`default_nettype wire

FILE: hdl/aabbt_axis.sv
// ----------------------------------------------------------------------------
// aabbt_axis
// One output axis: products, row sums, floor scaling, translation and
// saturation over pipeline stages two to five.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbt_axis (
   input  wire                                        clock,
   input  wire aabbt_pkg::stage_en_type               stage_en,
   input  wire [aabbt_pkg::AXES-1:0][aabbt_pkg::SUM_W-1:0]   s1,
   input  wire [aabbt_pkg::AXES-1:0][aabbt_pkg::COORD_W-1:0] d1,
   input  wire [aabbt_pkg::AXES-1:0][aabbt_pkg::ELEM_W-1:0]  row_m,
   input  wire [aabbt_pkg::COORD_W-1:0]               shift,
   input  wire                                        empty4,
   input  wire [aabbt_pkg::COORD_W-1:0]               pass_lo4,
   input  wire [aabbt_pkg::COORD_W-1:0]               pass_hi4,
   output logic [aabbt_pkg::COORD_W-1:0]              lo5,
   output logic [aabbt_pkg::COORD_W-1:0]              hi5
);
   import aabbt_pkg::*;

   logic [AXES-1:0][ELEM_W-1:0]   mabs_ff;
   logic [AXES-1:0][ELEM_W-1:0]   mabs_in;
   logic [AXES-1:0][PROD_A_W-1:0] prod_a_ff;
   logic [AXES-1:0][PROD_A_W-1:0] prod_a_in;
   logic [AXES-1:0][PROD_B_W-1:0] prod_b_ff;
   logic [AXES-1:0][PROD_B_W-1:0] prod_b_in;
   logic [ACC_A_W-1:0]            acc_a_ff, acc_a_in;
   logic [ACC_B_W-1:0]            acc_b_ff, acc_b_in;
   logic [SHIFT_W-1:0]            edge_lo_ff, edge_lo_in;
   logic [SHIFT_W-1:0]            edge_hi_ff, edge_hi_in;
   logic [EDGE_W-1:0]             diff, total;
   logic [OUT_W-1:0]              lo_full, hi_full;
   logic [COORD_W-1:0]            lo5_ff, lo5_in;
   logic [COORD_W-1:0]            hi5_ff, hi5_in;

   function automatic logic [COORD_W-1:0] sat(input logic [OUT_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v[OUT_W-1:COORD_W-1] == {(OUT_W-COORD_W+1){1'b0}} ||
          v[OUT_W-1:COORD_W-1] == {(OUT_W-COORD_W+1){1'b1}}) begin
         r = v[COORD_W-1:0];
      end else if (v[OUT_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      for (int j = 0; j < AXES; j++) begin
         mabs_in[j]   = row_m[j][ELEM_W-1] ? ELEM_W'(-row_m[j]) : row_m[j];
         prod_a_in[j] = PROD_A_W'($signed(s1[j])) * PROD_A_W'($signed(row_m[j]));
         prod_b_in[j] = PROD_B_W'(d1[j]) * PROD_B_W'(mabs_ff[j]);
      end
      acc_a_in = ACC_A_W'($signed(prod_a_ff[0])) + ACC_A_W'($signed(prod_a_ff[1]))
               + ACC_A_W'($signed(prod_a_ff[2]));
      acc_b_in = ACC_B_W'(prod_b_ff[0]) + ACC_B_W'(prod_b_ff[1])
               + ACC_B_W'(prod_b_ff[2]);
      diff  = EDGE_W'($signed(acc_a_ff)) - EDGE_W'(acc_b_ff);
      total = EDGE_W'($signed(acc_a_ff)) + EDGE_W'(acc_b_ff);
      edge_lo_in = diff[EDGE_W-1:FRAC_DROP];
      edge_hi_in = total[EDGE_W-1:FRAC_DROP];
      lo_full = OUT_W'($signed(edge_lo_ff)) + OUT_W'($signed(shift));
      hi_full = OUT_W'($signed(edge_hi_ff)) + OUT_W'($signed(shift));
      lo5_in  = empty4 ? pass_lo4 : sat(lo_full);
      hi5_in  = empty4 ? pass_hi4 : sat(hi_full);
   end

   always_ff @(posedge clock) begin
      mabs_ff <= mabs_in;
      if (stage_en.s2) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (stage_en.s3) begin
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
      if (stage_en.s4) begin
         edge_lo_ff <= edge_lo_in;
         edge_hi_ff <= edge_hi_in;
      end
      if (stage_en.s5) begin
         lo5_ff <= lo5_in;
         hi5_ff <= hi5_in;
      end
   end

   assign lo5 = lo5_ff;
   assign hi5 = hi5_ff;

endmodule

`default_nettype wire

FILE: hdl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Tight axis-aligned bounding box of a box under a configured affine map.
// ----------------------------------------------------------------------------
// Takes one box per clock unless rsp_tready stalls the pipeline, and
// presents its result through a five-stage pipeline: centre and width, nine
// signed 33 by 16 bit and nine unsigned 32 by 16 bit multipliers, row sums,
// floor scaling, then translation with saturation into the output register.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles close up under rsp_tready backpressure. An empty box (minimum above
// maximum on any axis) comes back unchanged with rsp_tuser set. Write the csr
// registers only while no request is in flight.
`default_nettype none

module aabb_affine_transform (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [aabbt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [aabbt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
   input  wire [aabbt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z
   output logic [aabbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // was_empty
   output logic                             rsp_tuser
);
   import aabbt_pkg::*;

   logic [COLUMN_W-1:0]             column_ff [AXES];
   logic [AXES-1:0][COORD_W-1:0]    shift_ff;

   logic                            v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                            adv1, adv2, adv3, adv4, adv5;
   stage_en_type                    stage_en;

   logic [AXES-1:0][COORD_W-1:0]    lo0, hi0;
   logic [AXES-1:0][SUM_W-1:0]      s1_ff, s1_in;
   logic [AXES-1:0][COORD_W-1:0]    d1_ff, d1_in;
   logic                            empty1_in;
   logic                            empty1_ff, empty2_ff, empty3_ff, empty4_ff, empty5_ff;
   logic [AXES-1:0][COORD_W-1:0]    lo1_ff, lo2_ff, lo3_ff, lo4_ff;
   logic [AXES-1:0][COORD_W-1:0]    hi1_ff, hi2_ff, hi3_ff, hi4_ff;
   logic [AXES-1:0][COORD_W-1:0]    lo5, hi5;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff[0] <= COLUMN0_RESET;
         column_ff[1] <= COLUMN1_RESET;
         column_ff[2] <= COLUMN2_RESET;
         shift_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COLUMN0: column_ff[0] <= csr_wdata;
            REG_COLUMN1: column_ff[1] <= csr_wdata;
            REG_COLUMN2: column_ff[2] <= csr_wdata;
            REG_SHIFT_X: shift_ff[0]  <= csr_wdata[COORD_W-1:0];
            REG_SHIFT_Y: shift_ff[1]  <= csr_wdata[COORD_W-1:0];
            REG_SHIFT_Z: shift_ff[2]  <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // advance a stage when it is empty or its successor advances
   always_comb begin
      adv5 = !v5_ff || rsp_tready;
      adv4 = !v4_ff || adv5;
      adv3 = !v3_ff || adv4;
      adv2 = !v2_ff || adv3;
      adv1 = !v1_ff || adv2;
      stage_en.s2 = adv2;
      stage_en.s3 = adv3;
      stage_en.s4 = adv4;
      stage_en.s5 = adv5;
   end

   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   always_comb begin
      empty1_in = 1'b0;
      for (int j = 0; j < AXES; j++) begin
         lo0[j]   = req_tdata[j*COORD_W +: COORD_W];
         hi0[j]   = req_tdata[(AXES+j)*COORD_W +: COORD_W];
         s1_in[j] = SUM_W'($signed(lo0[j])) + SUM_W'($signed(hi0[j]));
         d1_in[j] = hi0[j] - lo0[j];
         if ($signed(lo0[j]) > $signed(hi0[j])) begin
            empty1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff     <= s1_in;
         d1_ff     <= d1_in;
         empty1_ff <= empty1_in;
         lo1_ff    <= lo0;
         hi1_ff    <= hi0;
      end
      if (adv2) begin
         empty2_ff <= empty1_ff;
         lo2_ff    <= lo1_ff;
         hi2_ff    <= hi1_ff;
      end
      if (adv3) begin
         empty3_ff <= empty2_ff;
         lo3_ff    <= lo2_ff;
         hi3_ff    <= hi2_ff;
      end
      if (adv4) begin
         empty4_ff <= empty3_ff;
         lo4_ff    <= lo3_ff;
         hi4_ff    <= hi3_ff;
      end
      if (adv5) begin
         empty5_ff <= empty4_ff;
      end
   end

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      logic [AXES-1:0][ELEM_W-1:0] row_m;

      always_comb begin
         for (int j = 0; j < AXES; j++) begin
            row_m[j] = column_ff[j][i*ELEM_W +: ELEM_W];
         end
      end

      aabbt_axis u_axis (
         .clock    (clock),
         .stage_en (stage_en),
         .s1       (s1_ff),
         .d1       (d1_ff),
         .row_m    (row_m),
         .shift    (shift_ff[i]),
         .empty4   (empty4_ff),
         .pass_lo4 (lo4_ff[i]),
         .pass_hi4 (hi4_ff[i]),
         .lo5      (lo5[i]),
         .hi5      (hi5[i])
      );

      assign rsp_tdata[i*COORD_W +: COORD_W]        = lo5[i];
      assign rsp_tdata[(AXES+i)*COORD_W +: COORD_W] = hi5[i];
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tuser  = empty5_ff;

endmodule

`default_nettype wire
